// ===== sv/clsw_pkg.sv =====
`default_nettype none
package clsw_pkg;

  // Stencil shape and field widths
  localparam int STENCIL             = 4;
  localparam int OFF_W               = $clog2(STENCIL);
  localparam int CNT_W               = 2 * OFF_W;
  localparam int MAX_AXIS_POINTS_DEF = 1024;
  localparam int COORD_W             = 32;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 32;
  localparam int CNT_CFG_W           = 11;
  localparam int IDX_W               = 20;
  localparam int WEIGHT_W            = 32;
  localparam int WMAG_W              = 36;
  localparam int AXIS_DEPTH          = 17;

  // Reciprocal of three, exact for operands below 2^23 after a shift by 24
  localparam logic [22:0] RECIP3 = 23'd5592406;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_INV_SPACING = 3'd2,
    REG_POINTS_X    = 3'd3,
    REG_POINTS_Y    = 3'd4
  } cfg_reg_e;

  // One-dimensional weight as sign and magnitude, Q.24
  typedef struct packed {
    logic              neg;
    logic [WMAG_W-1:0] mag;
  } wt_t;

endpackage
`default_nettype wire

// ===== sv/clsw_if.sv =====
`default_nettype none
interface clsw_in_if import clsw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface clsw_out_if import clsw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           grid_index;
  logic [OFF_W-1:0]           column_offset;
  logic [OFF_W-1:0]           row_offset;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       last;
  modport source (output valid, grid_index, column_offset, row_offset, weight, last,
                  input ready);
  modport sink   (input valid, grid_index, column_offset, row_offset, weight, last,
                  output ready);
endinterface

interface clsw_cfg_if import clsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/cubic_lagrange_stencil_weights_core.sv =====
// The first result of a point leaves once its request has passed the axis pipe and the
// result pipe; the other fifteen follow one per cycle while the sink keeps ready high.
// Throughput is set by the weight product pipe, which emits one stencil result per cycle
// while the sink is ready; up to 17 points queue in the per-axis pipe.
// Reset: asynchronous, active low; clears valid bits and sequencer, loads register defaults.
`default_nettype none
module cubic_lagrange_stencil_weights_core import clsw_pkg::*; #(
  parameter int MAX_AXIS_POINTS = MAX_AXIS_POINTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  clsw_in_if.sink    in_if,
  clsw_out_if.source out_if,
  clsw_cfg_if.sink   cfg_if
);

  localparam int NW = $clog2(MAX_AXIS_POINTS + 1);
  localparam int SW = $clog2(MAX_AXIS_POINTS);

  logic signed [COORD_W-1:0] org_x_q, org_y_q;
  logic [31:0]               inv_q;
  logic [CNT_CFG_W-1:0]      npx_q, npy_q;
  logic [NW-1:0]             nx, ny;
  logic [AXIS_DEPTH-1:0]     vld_q;
  logic                      en_f, load;
  logic [SW-1:0]             xs, ys;
  wt_t                       wx [STENCIL];
  wt_t                       wy [STENCIL];

  // Configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      inv_q   <= 32'd65536;
      npx_q   <= CNT_CFG_W'(1024);
      npy_q   <= CNT_CFG_W'(1024);
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_ORIGIN_X:    org_x_q <= cfg_if.data;
        REG_ORIGIN_Y:    org_y_q <= cfg_if.data;
        REG_INV_SPACING: inv_q   <= cfg_if.data;
        REG_POINTS_X:    npx_q   <= cfg_if.data[CNT_CFG_W-1:0];
        REG_POINTS_Y:    npy_q   <= cfg_if.data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp point counts to the supported range
  function automatic logic [NW-1:0] eff_count(input logic [CNT_CFG_W-1:0] n);
    logic [31:0] c;
    c = 32'(n);
    if (c < 32'(STENCIL)) begin
      c = 32'(STENCIL);
    end else if (c > 32'(MAX_AXIS_POINTS)) begin
      c = 32'(MAX_AXIS_POINTS);
    end
    return c[NW-1:0];
  endfunction

  assign nx = eff_count(npx_q);
  assign ny = eff_count(npy_q);

  // Advance the axis pipe unless its last stage waits for the sequencer
  assign en_f        = !vld_q[AXIS_DEPTH-1] || load;
  assign in_if.ready = en_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_f) begin
      vld_q <= {vld_q[AXIS_DEPTH-2:0], in_if.valid};
    end
  end

  clsw_axis #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en_f),
    .coord_i  (in_if.point_x),
    .origin_i (org_x_q),
    .inv_i    (inv_q),
    .count_i  (nx),
    .start_o  (xs),
    .weight_o (wx)
  );

  clsw_axis #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en_f),
    .coord_i  (in_if.point_y),
    .origin_i (org_y_q),
    .inv_i    (inv_q),
    .count_i  (ny),
    .start_o  (ys),
    .weight_o (wy)
  );

  clsw_seq #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (vld_q[AXIS_DEPTH-1]),
    .item_load_o     (load),
    .xs_i            (xs),
    .ys_i            (ys),
    .wx_i            (wx),
    .wy_i            (wy),
    .nx_i            (nx),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .grid_index_o    (out_if.grid_index),
    .column_offset_o (out_if.column_offset),
    .row_offset_o    (out_if.row_offset),
    .weight_o        (out_if.weight),
    .last_o          (out_if.last)
  );

endmodule
`default_nettype wire

// ===== sv/clsw_axis.sv =====
`default_nettype none
module clsw_axis import clsw_pkg::*; #(
  parameter int MAX_AXIS_POINTS = MAX_AXIS_POINTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic signed [COORD_W-1:0] coord_i,
  input  wire logic signed [COORD_W-1:0] origin_i,
  input  wire logic [31:0]               inv_i,
  input  wire logic [$clog2(MAX_AXIS_POINTS+1)-1:0] count_i,
  output logic [$clog2(MAX_AXIS_POINTS)-1:0]        start_o,
  output wt_t                            weight_o [STENCIL]
);

  localparam int SW = $clog2(MAX_AXIS_POINTS);
  localparam int LW = 26;
  localparam logic [64:0] S_SAT = 65'(1) << 53;
  localparam logic signed [39:0] T_HI = 40'sd1048576;
  localparam logic signed [39:0] T_LO = -40'sd1048576;

  logic signed [32:0] d1_q;
  logic               neg2_q, neg3_q, neg4_q;
  logic [32:0]        dm2_q;
  logic [48:0]        phi3_q;
  logic [47:0]        plo3_q;
  logic [64:0]        mag_full;
  logic [53:0]        mag4_q;
  logic signed [54:0] s_w, s5_q, s6_q;
  logic signed [LW-1:0] left5_q, hi5_q, wl6_q;
  logic               loz5_q;
  logic signed [LW-1:0] wl, wr, ksum, nn, st, nm4, stc;
  logic [SW-1:0]      start7_q;
  logic signed [38:0] sf7_q;
  logic signed [39:0] traw, tcl;
  logic signed [21:0] t16_q;
  logic [SW-1:0]      st_q [8:17];
  logic signed [21:0] a9_q [STENCIL];
  logic signed [21:0] a10_q [STENCIL];
  logic signed [43:0] p01_q, p23_q;

  // Offset from the origin, then its magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= $signed({coord_i[COORD_W-1], coord_i})
                - $signed({origin_i[COORD_W-1], origin_i});
      neg2_q <= d1_q[32];
      dm2_q  <= d1_q[32] ? 33'(-d1_q) : d1_q;
    end
  end

  // Scale by inverse spacing in two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg3_q <= neg2_q;
      phi3_q <= 49'(dm2_q[32:16]) * 49'(inv_i);
      plo3_q <= 48'(dm2_q[15:0]) * 48'(inv_i);
    end
  end

  assign mag_full = {phi3_q, 16'h0000} + 65'(plo3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg4_q <= neg3_q;
      mag4_q <= (mag_full > S_SAT) ? S_SAT[53:0] : mag_full[53:0];
    end
  end

  // Signed grid coordinate, seed index and compare terms
  assign s_w = neg4_q ? -$signed({1'b0, mag4_q}) : $signed({1'b0, mag4_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q    <= s_w;
      left5_q <= neg4_q ? -$signed(LW'(mag4_q[53:32])) : $signed(LW'(mag4_q[53:32]));
      hi5_q   <= LW'(s_w >>> 31);
      loz5_q  <= (mag4_q[30:0] == 31'd0);
    end
  end

  // Grow the window toward the nearer neighbor
  assign nn = $signed(LW'(count_i));

  always_comb begin
    wl = left5_q;
    wr = left5_q + LW'(1);
    ksum = '0;
    for (int c = 0; c < STENCIL; c++) begin
      ksum = wl + wr;
      if (wl < 0) begin
        wr = wr + LW'(1);
      end else if (wr >= nn) begin
        wl = wl - LW'(1);
      end else if (hi5_q < ksum || (hi5_q == ksum && loz5_q)) begin
        wl = wl - LW'(1);
      end else begin
        wr = wr + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wl6_q <= wl;
      s6_q  <= s5_q;
    end
  end

  // Clamp the stencil start into the grid
  always_comb begin
    st  = wl6_q + LW'(1);
    nm4 = nn - LW'(STENCIL);
    if (st < 0) begin
      stc = '0;
    end else if (st > nm4) begin
      stc = nm4;
    end else begin
      stc = st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start7_q <= SW'(stc);
      sf7_q    <= 39'(s6_q >>> 16);
    end
  end

  // Offset from the start in Q.16, clamped to sixteen grid units
  assign traw = 40'(sf7_q) - $signed(40'({start7_q, 16'h0000}));

  always_comb begin
    if (traw > T_HI) begin
      tcl = T_HI;
    end else if (traw < T_LO) begin
      tcl = T_LO;
    end else begin
      tcl = traw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t16_q <= 22'(tcl);
    end
  end

  // Carry the start alongside the weight lanes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[8] <= start7_q;
      for (int k = 9; k <= 17; k++) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  assign start_o = st_q[17];

  // Node factors and their pair products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < STENCIL; j++) begin
        a9_q[j] <= 22'(t16_q - 22'(j * 65536));
      end
      a10_q <= a9_q;
      p01_q <= a9_q[0] * a9_q[1];
      p23_q <= a9_q[2] * a9_q[3];
    end
  end

  // One lane per node: numerator, magnitude, division by the fixed denominator
  for (genvar i = 0; i < STENCIL; i++) begin : g_lane
    localparam bit DEN6 = (i == 0) || (i == STENCIL - 1);
    localparam bit DNEG = (i % 2) == 0;

    logic signed [43:0] pp;
    logic signed [21:0] ff;
    logic signed [43:0] hp11_q;
    logic signed [44:0] lp11_q;
    logic signed [63:0] num12_q;
    logic [61:0]        m13_q;
    logic               ng13_q, ng14_q, ng15_q, ng16_q, ng17_q;
    logic [37:0]        u14_q;
    logic [WMAG_W-1:0]  mag17_q;

    assign pp = (i < 2) ? p23_q : p01_q;
    assign ff = a10_q[i ^ 1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hp11_q  <= $signed(pp[43:22]) * ff;
        lp11_q  <= $signed({1'b0, pp[21:0]}) * ff;
        num12_q <= (64'(hp11_q) <<< 22) + 64'(lp11_q);
        m13_q   <= num12_q[63] ? 62'(-num12_q) : num12_q[61:0];
        ng13_q  <= num12_q[63] ^ DNEG;
        ng14_q  <= ng13_q;
        ng15_q  <= ng14_q;
        ng16_q  <= ng15_q;
        ng17_q  <= ng16_q;
      end
    end

    if (DEN6) begin : g_div6
      logic [38:0] x6;
      logic [18:0] qh15_q;
      logic [19:0] yh15_q, rh;
      logic [17:0] yl15_q, qh16_q;
      logic [19:0] v16_q;
      logic [42:0] ph, pv;

      // Round by halves of six: floor((m/2^24 + 3) / 6) as a halving then a third
      assign x6 = 39'(m13_q[61:24]) + 39'd3;
      assign ph = 43'(u14_q[37:18]) * 43'(RECIP3);
      assign rh = yh15_q - 20'(qh15_q) * 20'd3;
      assign pv = 43'(v16_q) * 43'(RECIP3);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          u14_q   <= x6[38:1];
          qh15_q  <= ph[42:24];
          yh15_q  <= u14_q[37:18];
          yl15_q  <= u14_q[17:0];
          qh16_q  <= qh15_q[17:0];
          v16_q   <= {rh[1:0], yl15_q};
          mag17_q <= {qh16_q, pv[41:24]};
        end
      end
    end else begin : g_div2
      logic [62:0] x2;
      logic [37:0] u15_q, u16_q;

      assign x2 = 63'(m13_q) + (63'(1) << 24);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          u14_q   <= x2[62:25];
          u15_q   <= u14_q;
          u16_q   <= u15_q;
          mag17_q <= u16_q[WMAG_W-1:0];
        end
      end
    end

    assign weight_o[i] = '{neg: ng17_q, mag: mag17_q};
  end

endmodule
`default_nettype wire

// ===== sv/clsw_seq.sv =====
`default_nettype none
module clsw_seq import clsw_pkg::*; #(
  parameter int MAX_AXIS_POINTS = MAX_AXIS_POINTS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  item_valid_i,
  output logic                                       item_load_o,
  input  wire logic [$clog2(MAX_AXIS_POINTS)-1:0]    xs_i,
  input  wire logic [$clog2(MAX_AXIS_POINTS)-1:0]    ys_i,
  input  wire wt_t                                   wx_i [STENCIL],
  input  wire wt_t                                   wy_i [STENCIL],
  input  wire logic [$clog2(MAX_AXIS_POINTS+1)-1:0]  nx_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [IDX_W-1:0]                           grid_index_o,
  output logic [OFF_W-1:0]                           column_offset_o,
  output logic [OFF_W-1:0]                           row_offset_o,
  output logic signed [WEIGHT_W-1:0]                 weight_o,
  output logic                                       last_o
);

  localparam int NW = $clog2(MAX_AXIS_POINTS + 1);
  localparam int SW = $clog2(MAX_AXIS_POINTS);
  localparam int HW = WMAG_W / 2;
  localparam int PW = 2 * WMAG_W;
  localparam logic [CNT_W-1:0] LAST_K = CNT_W'(STENCIL * STENCIL - 1);

  typedef struct packed {
    logic [OFF_W-1:0] col;
    logic [OFF_W-1:0] row;
    logic             last;
    logic             neg;
  } meta_t;

  logic              en_c, seq_free, busy_q;
  logic [CNT_W-1:0]  k_q;
  logic [OFF_W-1:0]  ci, cj;
  logic [SW-1:0]     xs_q, ys_q;
  wt_t               wx_q [STENCIL];
  wt_t               wy_q [STENCIL];

  logic              c1_vld_q, c2_vld_q, c3_vld_q, c4_vld_q;
  meta_t             c1_m_q, c2_m_q, c3_m_q;
  logic [WMAG_W-1:0] c1_a_q, c1_b_q;
  logic [SW-1:0]     c1_row_q, c1_col_q, c2_col_q;
  logic [2*HW-1:0]   c2_hh_q, c2_hl_q, c2_lh_q, c2_ll_q;
  logic [SW+NW-1:0]  c2_rm_q;
  logic [PW-1:0]     c3_p_q;
  logic [63:0]       idx_w;
  logic [IDX_W-1:0]  c3_idx_q;
  logic              sat;
  logic [55:0]       rnd;
  logic [31:0]       r;
  logic [WEIGHT_W-1:0] w_d;

  // Advance the result pipe when its output register is free or taken
  assign en_c        = !c4_vld_q || out_ready_i;
  assign seq_free    = !busy_q || (en_c && k_q == LAST_K);
  assign item_load_o = seq_free && item_valid_i;
  assign ci          = k_q[CNT_W-1:OFF_W];
  assign cj          = k_q[OFF_W-1:0];

  // Stencil walk: column outer, row inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (item_load_o) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (en_c && busy_q) begin
      k_q <= k_q + CNT_W'(1);
      if (k_q == LAST_K) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the current point's starts and weights
  always_ff @(posedge clk_i) begin
    if (item_load_o) begin
      xs_q <= xs_i;
      ys_q <= ys_i;
      wx_q <= wx_i;
      wy_q <= wy_i;
    end
  end

  // Valid bits of the result pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      c3_vld_q <= 1'b0;
      c4_vld_q <= 1'b0;
    end else if (en_c) begin
      c1_vld_q <= busy_q;
      c2_vld_q <= c1_vld_q;
      c3_vld_q <= c2_vld_q;
      c4_vld_q <= c3_vld_q;
    end
  end

  // Pick the weight pair and grid index, split the product into partials, sum, round, saturate
  assign idx_w = 64'(c2_rm_q) + 64'(c2_col_q);
  assign sat   = |c3_p_q[PW-1:55];
  assign rnd   = 56'(c3_p_q[54:0]) + (56'(1) << 23);

  always_comb begin
    r = sat ? 32'h8000_0000 : rnd[55:24];
    if (c3_m_q.neg) begin
      w_d = 32'(-r);
    end else if (r[31]) begin
      w_d = 32'h7FFF_FFFF;
    end else begin
      w_d = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c1_a_q   <= wx_q[ci].mag;
      c1_b_q   <= wy_q[cj].mag;
      c1_m_q   <= '{col: ci, row: cj, last: (k_q == LAST_K),
                    neg: wx_q[ci].neg ^ wy_q[cj].neg};
      c1_row_q <= ys_q + SW'(cj);
      c1_col_q <= xs_q + SW'(ci);

      c2_hh_q  <= c1_a_q[WMAG_W-1:HW] * c1_b_q[WMAG_W-1:HW];
      c2_hl_q  <= c1_a_q[WMAG_W-1:HW] * c1_b_q[HW-1:0];
      c2_lh_q  <= c1_a_q[HW-1:0] * c1_b_q[WMAG_W-1:HW];
      c2_ll_q  <= c1_a_q[HW-1:0] * c1_b_q[HW-1:0];
      c2_rm_q  <= (SW+NW)'(c1_row_q) * (SW+NW)'(nx_i);
      c2_col_q <= c1_col_q;
      c2_m_q   <= c1_m_q;

      c3_p_q   <= (PW'(c2_hh_q) << (2 * HW)) + ((PW'(c2_hl_q) + PW'(c2_lh_q)) << HW)
                  + PW'(c2_ll_q);
      c3_idx_q <= idx_w[IDX_W-1:0];
      c3_m_q   <= c2_m_q;

      grid_index_o    <= c3_idx_q;
      column_offset_o <= c3_m_q.col;
      row_offset_o    <= c3_m_q.row;
      last_o          <= c3_m_q.last;
      weight_o        <= w_d;
    end
  end

  assign out_valid_o = c4_vld_q;

endmodule
`default_nettype wire

// ===== sv/clsw_checker.sv =====
`default_nettype none
module clsw_checker import clsw_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [IDX_W-1:0]           grid_index_i,
  input wire logic [OFF_W-1:0]           column_offset_i,
  input wire logic [OFF_W-1:0]           row_offset_i,
  input wire logic signed [WEIGHT_W-1:0] weight_i,
  input wire logic                       last_i
);

  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(STENCIL - 1);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(grid_index_i)
      && $stable(weight_i) && $stable(column_offset_i) && $stable(row_offset_i)
      && $stable(last_i))
    else $error("stalled result changed");

  // Last marks the corner of the stencil and nothing else
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (column_offset_i == OFF_MAX && row_offset_i == OFF_MAX)))
    else $error("last flag does not match stencil corner");

  // Results of a point come in stencil order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> !out_valid_i
      || {column_offset_i, row_offset_i} == $past({column_offset_i, row_offset_i})
         + (2*OFF_W)'(1))
    else $error("stencil result out of order");

  // No result during reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid in reset");

endmodule

bind cubic_lagrange_stencil_weights_core clsw_checker u_clsw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .grid_index_i    (out_if.grid_index),
  .column_offset_i (out_if.column_offset),
  .row_offset_i    (out_if.row_offset),
  .weight_i        (out_if.weight),
  .last_i          (out_if.last)
);
`default_nettype wire

// ===== tb/sv/clsw_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module clsw_scoreboard import clsw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clsw_in_if        in_if,
  clsw_out_if       out_if,
  clsw_cfg_if       cfg_if,
  output int        errors_o,
  output int        pending_o
);

  localparam longint unsigned S_SAT = 64'd1 << 53;
  localparam longint          T_LIM = 64'sd16 <<< 32;
  localparam longint          UNIT  = 64'sd1 <<< 32;
  localparam longint unsigned W_LIM = (64'd1 << 55) - 64'd1;

  typedef struct packed {
    logic [IDX_W-1:0]    grid_index;
    logic [OFF_W-1:0]    column_offset;
    logic [OFF_W-1:0]    row_offset;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } stencil_pt_t;

  stencil_pt_t weight_q[$];
  int          err_cnt;

  // Shadow copy of the grid registers
  longint      org_x, org_y;
  logic [31:0] inv_spacing;
  logic [10:0] pts_x, pts_y;

  function automatic longint clamp_count(logic [10:0] n);
    if (n < STENCIL) return STENCIL;
    if (n > MAX_AXIS_POINTS_DEF) return MAX_AXIS_POINTS_DEF;
    return longint'(n);
  endfunction

  // Grow the window toward the nearer neighbour, return its start and offset t
  function automatic longint stencil_start(longint q, longint org, longint n,
                                           output longint t16);
    longint            d, s, left, right, start, t;
    logic              neg;
    longint unsigned   dm, mag;
    d = q - org;
    neg = d < 0;
    dm = neg ? longint'(-d) : d;
    mag = dm * longint'({32'd0, inv_spacing});
    if (mag > S_SAT) mag = S_SAT;
    s = neg ? -longint'(mag) : longint'(mag);
    left = longint'(mag >> 32);
    if (neg) left = -left;
    right = left + 1;
    for (int c = 0; c < STENCIL; c++) begin
      if (left < 0) right++;
      else if (right >= n) left--;
      else if (2 * s <= (left + right) * UNIT) left--;
      else right++;
    end
    start = left + 1;
    if (start < 0) start = 0;
    if (start > n - STENCIL) start = n - STENCIL;
    t = s - start * UNIT;
    if (t < -T_LIM) t = -T_LIM;
    if (t > T_LIM) t = T_LIM;
    t16 = longint'(longint'(unsigned'(t + T_LIM)) >>> 16) - (T_LIM >>> 16);
    return start;
  endfunction

  // 1D Lagrange weight of node i, Q.24, rounded half away from zero
  function automatic longint lagrange_1d(longint t16, int i);
    longint          num, den;
    longint unsigned m, dd, q;
    logic            neg;
    num = 1;
    den = 1;
    for (int j = 0; j < STENCIL; j++) begin
      if (j != i) begin
        num = num * (t16 - longint'(j) * 65536);
        den = den * longint'(i - j);
      end
    end
    neg = (num < 0) != (den < 0);
    m = num < 0 ? longint'(-num) : num;
    dd = (den < 0 ? longint'(-den) : den) << 24;
    q = (m + dd / 2) / dd;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Product of the two axis weights, rounded and saturated to Q8.24
  function automatic logic [31:0] tensor_weight(longint wx, longint wy);
    logic            neg;
    longint unsigned a, b, r;
    neg = (wx < 0) != (wy < 0);
    a = wx < 0 ? longint'(-wx) : wx;
    b = wy < 0 ? longint'(-wy) : wy;
    if (a != 0 && b > W_LIM / a) r = 64'd1 << 31;
    else r = (a * b + (64'd1 << 23)) >> 24;
    if (neg) begin
      if (r > (64'd1 << 31)) r = 64'd1 << 31;
      return 32'(64'd0 - r);
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return r[31:0];
  endfunction

  task automatic push_stencil(longint px, longint py);
    longint      nx, ny, xs, ys, tx, ty;
    longint      wx[STENCIL], wy[STENCIL];
    stencil_pt_t p;
    nx = clamp_count(pts_x);
    ny = clamp_count(pts_y);
    xs = stencil_start(px, org_x, nx, tx);
    ys = stencil_start(py, org_y, ny, ty);
    for (int i = 0; i < STENCIL; i++) begin
      wx[i] = lagrange_1d(tx, i);
      wy[i] = lagrange_1d(ty, i);
    end
    for (int i = 0; i < STENCIL; i++) begin
      for (int j = 0; j < STENCIL; j++) begin
        p.grid_index    = IDX_W'((ys + j) * nx + xs + i);
        p.column_offset = OFF_W'(i);
        p.row_offset    = OFF_W'(j);
        p.weight        = tensor_weight(wx[i], wy[j]);
        p.last          = (i == STENCIL - 1) && (j == STENCIL - 1);
        weight_q.push_back(p);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stencil_pt_t e;
    if (!rst_ni) begin
      org_x       = 0;
      org_y       = 0;
      inv_spacing = 32'd65536;
      pts_x       = 11'd1024;
      pts_y       = 11'd1024;
      weight_q.delete();
      err_cnt     = 0;
    end else begin
      // Track register writes
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_ORIGIN_X:    org_x = longint'(signed'(cfg_if.data));
          REG_ORIGIN_Y:    org_y = longint'(signed'(cfg_if.data));
          REG_INV_SPACING: inv_spacing = cfg_if.data;
          REG_POINTS_X:    pts_x = cfg_if.data[10:0];
          REG_POINTS_Y:    pts_y = cfg_if.data[10:0];
          default: ;
        endcase
      end
      // Compare each result against the oldest expectation
      if (out_if.valid && out_if.ready) begin
        if (weight_q.size() == 0) begin
          $error("result with nothing expected: index %0d", out_if.grid_index);
          err_cnt++;
        end else begin
          e = weight_q.pop_front();
          if (out_if.grid_index !== e.grid_index) begin
            $error("grid_index exp %0d got %0d", e.grid_index, out_if.grid_index);
            err_cnt++;
          end
          if (out_if.column_offset !== e.column_offset) begin
            $error("column_offset exp %0d got %0d", e.column_offset, out_if.column_offset);
            err_cnt++;
          end
          if (out_if.row_offset !== e.row_offset) begin
            $error("row_offset exp %0d got %0d", e.row_offset, out_if.row_offset);
            err_cnt++;
          end
          if (out_if.weight !== e.weight) begin
            $error("weight exp %h got %h", e.weight, out_if.weight);
            err_cnt++;
          end
          if (out_if.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, out_if.last);
            err_cnt++;
          end
        end
      end
      // Predict the stencil of each accepted request
      if (in_if.valid && in_if.ready)
        push_stencil(longint'(in_if.point_x), longint'(in_if.point_y));
    end
  end

  assign errors_o  = err_cnt;
  assign pending_o = weight_q.size();

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import clsw_pkg::*;

  localparam int WATCHDOG = 3000;
  localparam int HOLD_LEN = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;
  bit   no_gaps = 1'b0;

  clsw_in_if  in_if ();
  clsw_out_if out_if ();
  clsw_cfg_if cfg_if ();

  cubic_lagrange_stencil_weights_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  clsw_scoreboard chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_if    (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid   = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sink side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.point_x <= x;
    in_if.point_y <= y;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop the request and wait until every stencil has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic load_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] inv,
                           logic [31:0] nx, logic [31:0] ny);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_SPACING, inv);
    write_reg(REG_POINTS_X, nx);
    write_reg(REG_POINTS_Y, ny);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly points near the grid, some anywhere in the coordinate range
  task automatic random_points(int count, logic [31:0] ox, logic [31:0] oy,
                               int span, int margin);
    logic [31:0] x, y;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = ox + $urandom_range(0, span) - margin;
        y = oy + $urandom_range(0, span) - margin;
      end
      send_point(x, y);
    end
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // Default grid: extremes, exact nodes, ties and edges
    send_point(32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0005_0000, 32'h0005_8000);
    send_point(32'h0005_4000, 32'h0000_8000);
    send_point(32'h03FF_0000, 32'h03FE_E666);
    send_point(32'hFFFF_0000, 32'h03FC_8000);
    send_point(32'h0000_FFFF, 32'h0002_8000);
    send_point(32'hFFFF_FFFF, 32'h03FF_FFFF);
    send_point(32'h0400_0000, 32'hFFF0_0000);

    // Small offset grid, half spacing; long sink hold-off fills the block
    load_grid(32'h000A_8000, 32'hFFFD_0000, 32'h0002_0000, 32'd7, 32'd4);
    send_point(32'h000A_8000, 32'hFFFD_0000);
    hold_req = 1'b1;
    no_gaps = 1'b1;
    random_points(30, 32'h000A_8000, 32'hFFFD_0000, 32'h0006_0000, 32'h0001_0000);
    no_gaps = 1'b0;
    drain();
    random_points(20, 32'h000A_8000, 32'hFFFD_0000, 32'h0006_0000, 32'h0001_0000);

    // Out-of-range counts, finest spacing, extreme origins
    load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd2047);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0100, 32'h7FFF_FF00);
    random_points(10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0800, 32'h0000_0400);

    // Zero inverse spacing maps everything to node 0
    load_grid(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 32'd1024, 32'd1024);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    random_points(5, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h4000_0000);

    // Widest spacing, counts just past either limit
    load_grid(32'h0, 32'h0, 32'h1, 32'd1025, 32'd3);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    random_points(10, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h4000_0000);

    // Minimum grid at unit spacing
    load_grid(32'h0, 32'h0, 32'h0001_0000, 32'd4, 32'd4);
    random_points(20, 32'h0, 32'h0, 32'h0006_0000, 32'h0001_0000);

    // Unit spacing again, offset origins and a mid-sized grid
    load_grid(32'hFFF0_0000, 32'h0010_0000, 32'h0001_0000, 32'd1024, 32'd37);
    random_points(25, 32'hFFF0_0000, 32'h0010_0000, 32'h0400_0000, 32'h0002_0000);

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
